### design/frt_pkg.sv
`timescale 1ns / 1ps

package frt_pkg;

   localparam int CNT_W = 7;

   localparam logic [11:0] MAX_DATAGRAM = 12'd2048;
   localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

   localparam logic CMD_FRAGMENT = 1'b0;
   localparam logic CMD_SWEEP    = 1'b1;

   localparam logic [3:0] STAT_STORED     = 4'd0;
   localparam logic [3:0] STAT_DUPLICATE  = 4'd1;
   localparam logic [3:0] STAT_COMPLETE   = 4'd2;
   localparam logic [3:0] STAT_BAD_HEADER = 4'd3;
   localparam logic [3:0] STAT_BAD_INDEX  = 4'd4;
   localparam logic [3:0] STAT_MISMATCH   = 4'd5;
   localparam logic [3:0] STAT_TABLE_FULL = 4'd6;
   localparam logic [3:0] STAT_STALE      = 4'd7;
   localparam logic [3:0] STAT_SWEEP_DONE = 4'd8;

   typedef struct packed {
      logic        command;
      logic        header_valid;
      logic [11:0] fragment_length;
      logic [31:0] frame_seq;
      logic [15:0] frag_index;
      logic [15:0] frag_count;
      logic [63:0] capture_time;
      logic [31:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [3:0]       status;
      logic [31:0]      result_seq;
      logic [63:0]      result_capture_time;
      logic [CNT_W-1:0] got_fragments;
      logic [CNT_W-1:0] expected_fragments;
      logic [3:0]       pending_frames;
      logic [31:0]      stale_drops;
      logic             last;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0]      seq;
      logic [CNT_W-1:0] expected;
      logic [CNT_W-1:0] got;
      logic [31:0]      first_ms;
      logic [63:0]      capture;
   } entry_rec_type;

   typedef enum logic {
      CMP_EQUAL,
      CMP_AGE
   } cmp_op_type;

   typedef struct packed {
      cmp_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] limit;
   } cmp_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_COMPARE,
      ST_APPLY,
      ST_CLOSE,
      ST_EMIT
   } seq_state_type;

endpackage

### design/frt_req_if.sv
`timescale 1ns / 1ps

interface frt_req_if import frt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### design/frt_rsp_if.sv
`timescale 1ns / 1ps

interface frt_rsp_if import frt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

### design/frt_cmp_unit.sv
`timescale 1ns / 1ps

module frt_cmp_unit import frt_pkg::*; (
   input  cmp_req_type cmp_req,
   output logic        hit
);

   logic [31:0] diff;

   // ages wrap modulo 2^32
   assign diff = cmp_req.a - cmp_req.b;

   always_comb begin
      unique case (cmp_req.op)
         CMP_EQUAL: hit = (cmp_req.a == cmp_req.b);
         CMP_AGE:   hit = (diff >= cmp_req.limit);
         default:   hit = 1'b0;
      endcase
   end

endmodule

### design/frt_entry_mem.sv
`timescale 1ns / 1ps

module frt_entry_mem import frt_pkg::*; #(
   parameter int DEPTH  = 8,
   parameter int MASK_W = 64,
   parameter int IDX_W  = 3
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output entry_rec_type     rd_rec,
   output logic [MASK_W-1:0] rd_mask,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  entry_rec_type     wr_rec,
   input  logic [MASK_W-1:0] wr_mask
);

   entry_rec_type     rec_mem [DEPTH];
   logic [MASK_W-1:0] mask_mem [DEPTH];
   entry_rec_type     rd_rec_ff;
   logic [MASK_W-1:0] rd_mask_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr]  <= wr_rec;
         mask_mem[wr_addr] <= wr_mask;
      end
      if (rd_en) begin
         rd_rec_ff  <= rec_mem[rd_addr];
         rd_mask_ff <= mask_mem[rd_addr];
      end
   end

   assign rd_rec  = rd_rec_ff;
   assign rd_mask = rd_mask_ff;

endmodule

### design/frt_seq.sv
`timescale 1ns / 1ps

module frt_seq import frt_pkg::*; #(
   parameter int MAX_PENDING  = 8,
   parameter int MAX_FRAGS    = 64,
   parameter int HEADER_BYTES = 24,
   parameter int IDX_W        = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_word_type         req_word,
   output logic                 req_ready,
   input  logic                 out_free,
   output logic                 rsp_load,
   output rsp_word_type         rsp_word,
   input  logic [31:0]          timeout,
   output logic                 mem_rd_en,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  entry_rec_type        mem_rd_rec,
   input  logic [MAX_FRAGS-1:0] mem_rd_mask,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output entry_rec_type        mem_wr_rec,
   output logic [MAX_FRAGS-1:0] mem_wr_mask,
   output cmp_req_type          cmp_req,
   input  logic                 cmp_hit
);

   localparam int PC_W   = $clog2(MAX_PENDING + 1);
   localparam int MIDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
   localparam logic [11:0]      HDR_MIN   = 12'(HEADER_BYTES);
   localparam logic [15:0]      FRAGS_MAX = 16'(MAX_FRAGS);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_PENDING - 1);

   seq_state_type        state_ff, state_in;
   req_word_type         req_ff, req_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     free_ff, free_in;
   logic                 free_found_ff, free_found_in;
   logic                 new_ff, new_in;
   entry_rec_type        cur_rec_ff, cur_rec_in;
   logic [MAX_FRAGS-1:0] cur_mask_ff, cur_mask_in;
   logic [MAX_PENDING-1:0] valid_ff, valid_in;
   logic [PC_W-1:0]      pending_ff, pending_in;
   logic [31:0]          stale_ff, stale_in;
   rsp_word_type         res_ff, res_in;

   logic                 req_fire;
   logic                 is_sweep;
   logic                 scan_last;
   logic                 entry_v;
   logic                 match;
   logic                 free_now;
   logic                 bad_hdr;
   logic                 bad_idx;
   logic                 mismatch;
   logic                 dup;
   logic                 complete;
   logic [CNT_W-1:0]     got_next;
   logic [MIDX_W-1:0]    bit_pos;
   logic [MAX_FRAGS-1:0] bit_onehot;
   logic [PC_W+3:0]      pending_wide;

   assign req_fire  = req_valid && req_ready;
   assign is_sweep  = (req_ff.command == CMD_SWEEP);
   assign scan_last = (idx_ff == IDX_LAST);
   assign entry_v   = valid_ff[idx_ff];
   assign match     = entry_v && cmp_hit;
   assign free_now  = free_found_ff || !entry_v;

   assign bad_hdr = !req_ff.header_valid || (req_ff.fragment_length < HDR_MIN)
                    || (req_ff.fragment_length > MAX_DATAGRAM);
   assign bad_idx = (req_ff.frag_count == 16'd0) || (req_ff.frag_count > FRAGS_MAX)
                    || (req_ff.frag_index >= req_ff.frag_count);

   assign bit_pos    = req_ff.frag_index[MIDX_W-1:0];
   assign bit_onehot = MAX_FRAGS'(1) << bit_pos;
   assign mismatch   = (16'(cur_rec_ff.expected) != req_ff.frag_count);
   assign dup        = cur_mask_ff[bit_pos];
   assign got_next   = cur_rec_ff.got + CNT_W'(1);
   assign complete   = (got_next == cur_rec_ff.expected);

   // shared compare: sequence lookup, or age test on a sweep
   always_comb begin
      cmp_req.limit = timeout;
      if (is_sweep) begin
         cmp_req.op = CMP_AGE;
         cmp_req.a  = req_ff.now_ms;
         cmp_req.b  = mem_rd_rec.first_ms;
      end else begin
         cmp_req.op = CMP_EQUAL;
         cmp_req.a  = mem_rd_rec.seq;
         cmp_req.b  = req_ff.frame_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         pending_ff <= '0;
         stale_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
         stale_ff   <= stale_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      new_ff        <= new_in;
      cur_rec_ff    <= cur_rec_in;
      cur_mask_ff   <= cur_mask_in;
      res_ff        <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!is_sweep && (bad_hdr || bad_idx)) state_in = ST_EMIT;
            else state_in = ST_READ;
         end
         ST_READ: state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (is_sweep) begin
               if (match) state_in = ST_EMIT;
               else if (scan_last) state_in = ST_CLOSE;
               else state_in = ST_READ;
            end else begin
               if (match) state_in = ST_APPLY;
               else if (scan_last) state_in = free_now ? ST_APPLY : ST_EMIT;
               else state_in = ST_READ;
            end
         end
         ST_APPLY: state_in = ST_EMIT;
         ST_CLOSE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (res_ff.last) state_in = ST_IDLE;
               else if (scan_last) state_in = ST_CLOSE;
               else state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and strobes
   always_comb begin
      req_in        = req_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      new_in        = new_ff;
      cur_rec_in    = cur_rec_ff;
      cur_mask_in   = cur_mask_ff;
      valid_in      = valid_ff;
      pending_in    = pending_ff;
      stale_in      = stale_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_rec    = cur_rec_ff;
      mem_wr_rec.got = got_next;
      mem_wr_mask   = cur_mask_ff | bit_onehot;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_fire) req_in = req_word;
         end
         ST_CHECK: begin
            idx_in        = '0;
            free_found_in = 1'b0;
            res_in        = '0;
            res_in.result_seq = req_ff.frame_seq;
            res_in.last   = 1'b1;
            res_in.status = bad_hdr ? STAT_BAD_HEADER : STAT_BAD_INDEX;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
         end
         ST_COMPARE: begin
            if (is_sweep) begin
               if (match) begin
                  valid_in[idx_ff] = 1'b0;
                  pending_in       = pending_ff - PC_W'(1);
                  if (stale_ff != '1) stale_in = stale_ff + 32'd1;
                  res_in.status              = STAT_STALE;
                  res_in.result_seq          = mem_rd_rec.seq;
                  res_in.result_capture_time = mem_rd_rec.capture;
                  res_in.got_fragments       = mem_rd_rec.got;
                  res_in.expected_fragments  = mem_rd_rec.expected;
                  res_in.last                = 1'b0;
               end else if (!scan_last) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               if (!entry_v && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = idx_ff;
               end
               if (match) begin
                  slot_in     = idx_ff;
                  cur_rec_in  = mem_rd_rec;
                  cur_mask_in = mem_rd_mask;
                  new_in      = 1'b0;
               end else if (scan_last) begin
                  if (free_now) begin
                     slot_in             = free_found_ff ? free_ff : idx_ff;
                     cur_rec_in.seq      = req_ff.frame_seq;
                     cur_rec_in.expected = req_ff.frag_count[CNT_W-1:0];
                     cur_rec_in.got      = '0;
                     cur_rec_in.first_ms = req_ff.now_ms;
                     cur_rec_in.capture  = req_ff.capture_time;
                     cur_mask_in         = '0;
                     new_in              = 1'b1;
                  end else begin
                     res_in.status = STAT_TABLE_FULL;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_APPLY: begin
            res_in.result_seq          = req_ff.frame_seq;
            res_in.result_capture_time = cur_rec_ff.capture;
            res_in.got_fragments       = cur_rec_ff.got;
            res_in.expected_fragments  = cur_rec_ff.expected;
            res_in.last                = 1'b1;
            if (mismatch) begin
               res_in.status = STAT_MISMATCH;
            end else if (dup) begin
               res_in.status = STAT_DUPLICATE;
            end else begin
               mem_wr_en              = 1'b1;
               valid_in[slot_ff]      = !complete;
               res_in.got_fragments   = got_next;
               res_in.status          = complete ? STAT_COMPLETE : STAT_STORED;
               if (new_ff && !complete) pending_in = pending_ff + PC_W'(1);
               else if (!new_ff && complete) pending_in = pending_ff - PC_W'(1);
            end
         end
         ST_CLOSE: begin
            res_in        = '0;
            res_in.status = STAT_SWEEP_DONE;
            res_in.last   = 1'b1;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (!res_ff.last && !scan_last) idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign pending_wide = {4'b0, pending_ff};

   always_comb begin
      rsp_word                = res_ff;
      rsp_word.pending_frames = pending_wide[3:0];
      rsp_word.stale_drops    = stale_ff;
   end

endmodule

### design/fragment_reassembly_table_unit.sv
`timescale 1ns / 1ps

// port      dir  handshake                word
// req_bus   in   valid / ready            command, header and timing fields
// rsp_bus   out  valid / ready            status, frame fields, counters, last
// csr_*     in   csr_wr_en, no wait       stale_timeout
//
// a fragment is looked up entry by entry: each entry is read and then checked
// by the one shared compare unit; a bad header or index skips the scan
// a sweep scans every entry and emits one word for each dropped frame
// reset clears the valid bits, pending and drop counters and sets the timeout to 1000
// a stalled rsp_bus holds the sequencer at its emit step; one finished word waits
// in the output register while the next request can be taken

module fragment_reassembly_table_unit import frt_pkg::*; #(
   parameter int MAX_PENDING  = 8,
   parameter int MAX_FRAGS    = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic        clock,
   input  logic        reset,
   frt_req_if.sink     req_bus,
   frt_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

   logic [31:0]          timeout_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_ff;
   logic                 out_free;
   logic                 rsp_load;
   rsp_word_type         rsp_word;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   entry_rec_type        mem_rd_rec;
   logic [MAX_FRAGS-1:0] mem_rd_mask;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   entry_rec_type        mem_wr_rec;
   logic [MAX_FRAGS-1:0] mem_wr_mask;
   cmp_req_type          cmp_req;
   logic                 cmp_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_word;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.word  = rsp_ff;

   frt_seq #(
      .MAX_PENDING  (MAX_PENDING),
      .MAX_FRAGS    (MAX_FRAGS),
      .HEADER_BYTES (HEADER_BYTES),
      .IDX_W        (IDX_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_word    (req_bus.word),
      .req_ready   (req_bus.ready),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_word    (rsp_word),
      .timeout     (timeout_ff),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_rec  (mem_rd_rec),
      .mem_rd_mask (mem_rd_mask),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_rec  (mem_wr_rec),
      .mem_wr_mask (mem_wr_mask),
      .cmp_req     (cmp_req),
      .cmp_hit     (cmp_hit)
   );

   frt_entry_mem #(
      .DEPTH  (MAX_PENDING),
      .MASK_W (MAX_FRAGS),
      .IDX_W  (IDX_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_rec  (mem_rd_rec),
      .rd_mask (mem_rd_mask),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_rec  (mem_wr_rec),
      .wr_mask (mem_wr_mask)
   );

   frt_cmp_unit u_cmp (
      .cmp_req (cmp_req),
      .hit     (cmp_hit)
   );

endmodule
